[sv/wct_pkg.sv]
package wct_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 48;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int HGT_W      = 11;
    localparam int ROW_W      = 10;
    localparam int RAD_W      = 2;
    localparam int MAX_HEIGHT = 1024;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_RADIUS = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 4'd0,
        CFG_IMAGE_HEIGHT = 4'd1,
        CFG_RADIUS       = 4'd2,
        CFG_TERNARY_MODE = 4'd3
    } cfg_index_t;

    localparam logic [1:0] TERN_GT = 2'b01;
    localparam logic [1:0] TERN_LT = 2'b00;
    localparam logic [1:0] TERN_EQ = 2'b10;

    typedef struct packed {
        logic             adv;
        logic             move;
        logic             bypass;
        logic             last;
        logic             ternary;
        logic [RAD_W-1:0] radius;
    } wct_step_t;

endpackage

[sv/wct_row_cell.sv]
module wct_row_cell #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
) (
    input  logic                                         aclk,
    input  logic                                         adv,
    input  logic                                         bypass,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 ptr,
    input  logic [wct_pkg::PIX_W-1:0]                    din,
    output logic [2*MAX_RADIUS:0][wct_pkg::PIX_W-1:0]    taps
);
    import wct_pkg::*;

    localparam int TAPS  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = MAX_WIDTH - 1;

    logic [PIX_W-1:0]            mem [DEPTH];
    logic [TAPS-1:0][PIX_W-1:0]  taps_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mem[ptr]    <= din;
            taps_reg[0] <= bypass ? din : mem[ptr];
            for (int i = 1; i < TAPS; i++) begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

    assign taps = taps_reg;

endmodule

[sv/wct_census.sv]
module wct_census #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
) (
    input  logic [2*MAX_RADIUS:0][2*MAX_RADIUS:0][wct_pkg::PIX_W-1:0] win,
    input  logic [wct_pkg::ROW_W-1:0]                                 row,
    input  logic [$clog2(MAX_WIDTH)-1:0]                              col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                            img_w,
    input  logic [wct_pkg::HGT_W-1:0]                                 img_h,
    input  logic [wct_pkg::RAD_W-1:0]                                 radius,
    input  logic                                                      ternary,
    output logic [wct_pkg::CODE_W-1:0]                                code
);
    import wct_pkg::*;

    localparam int TAPS = 2 * MAX_RADIUS + 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = ROW_W + 3;
    localparam int XXW  = WW + 2;

    logic [TAPS-1:0] row_ok;
    logic [TAPS-1:0] col_ok;

    always_comb begin
        logic signed [YW-1:0]  yy;
        logic signed [XXW-1:0] xx;
        for (int j = 0; j < TAPS; j++) begin
            yy = $signed(YW'(row)) + $signed(YW'(radius)) - YW'(j);
            xx = $signed(XXW'(col)) + $signed(XXW'(radius)) - XXW'(j);
            row_ok[j] = (yy >= 0) && (yy < $signed(YW'(img_h)));
            col_ok[j] = (xx >= 0) && (xx < $signed(XXW'(img_w)));
        end
    end

    always_comb begin
        int               q;
        int               qc;
        int               nn;
        int               m;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] nb;
        code = '0;
        c    = '0;
        nb   = '0;
        q    = 0;
        qc   = 0;
        nn   = 0;
        m    = 0;
        for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
            if (radius == RAD_W'(rr)) begin
                c  = win[rr][rr];
                qc = rr * (2 * rr + 1) + rr;
                nn = (2 * rr + 1) * (2 * rr + 1) - 1;
                for (int j = 0; j <= 2 * rr; j++) begin
                    for (int i = 0; i <= 2 * rr; i++) begin
                        q = (2 * rr - j) * (2 * rr + 1) + (2 * rr - i);
                        m = (q < qc) ? q : q - 1;
                        nb = (row_ok[j] && col_ok[i]) ? win[j][i] : '0;
                        if (q != qc) begin
                            if (ternary) begin
                                code[2*(nn-1-m) +: 2] = (c > nb) ? TERN_GT :
                                                        (c < nb) ? TERN_LT : TERN_EQ;
                            end else begin
                                code[nn-1-m] = (c >= nb);
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

[sv/wct_ctrl.sv]
module wct_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [wct_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wct_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic                                  out_free,
    output wct_pkg::wct_step_t                    step,
    output logic [$clog2(MAX_WIDTH)-1:0]          ptr,
    output logic [$clog2(MAX_WIDTH)-1:0]          col,
    output logic [wct_pkg::ROW_W-1:0]             row,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        img_w,
    output logic [wct_pkg::HGT_W-1:0]             img_h
);
    import wct_pkg::*;

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int DW      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WW-1:0]    w_reg, w_next;
    logic [HGT_W-1:0] h_reg, h_next;
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic             ternary_reg, ternary_next;
    logic [DW-1:0]    cnt_reg, cnt_next;
    logic [XW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [XW-1:0]    ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [XW-1:0]    pend_col_reg;
    logic [ROW_W-1:0] pend_row_reg;
    logic             pend_last_reg;

    logic             adv;
    logic             move;
    logic             produce;
    logic             col_end;
    logic             row_end;
    logic             frame_end;
    logic [DW-1:0]    delay;
    logic [WW-1:0]    w_wr;
    logic [HGT_W-1:0] h_wr;
    logic [RAD_W-1:0] r_wr;

    assign s_tready  = !pend_reg || out_free;
    assign adv       = s_tvalid && s_tready;
    assign move      = pend_reg && out_free;
    assign delay     = DW'(w_reg) + ((radius_reg > RAD_W'(1)) ? DW'(w_reg) : DW'(0))
                     + DW'(radius_reg);
    assign produce   = (cnt_reg >= delay);
    assign col_end   = (WW'(col_reg) + WW'(1) == w_reg);
    assign row_end   = (HGT_W'(row_reg) + HGT_W'(1) == h_reg);
    assign frame_end = col_end && row_end;

    assign w_wr = (cfg_wdata == '0) ? WW'(1) :
                  (32'(cfg_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_wdata);
    assign h_wr = (cfg_wdata == '0) ? HGT_W'(1) :
                  (32'(cfg_wdata) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : cfg_wdata;
    assign r_wr = (cfg_wdata[RAD_W-1:0] == '0) ? RAD_W'(1) :
                  (32'(cfg_wdata[RAD_W-1:0]) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) :
                  cfg_wdata[RAD_W-1:0];

    always_comb begin
        w_next       = w_reg;
        h_next       = h_reg;
        radius_next  = radius_reg;
        ternary_next = ternary_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        ptr_next     = ptr_reg;
        pend_next    = adv ? produce : (move ? 1'b0 : pend_reg);
        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  w_next       = w_wr;
                CFG_IMAGE_HEIGHT: h_next       = h_wr;
                CFG_RADIUS:       radius_next  = r_wr;
                CFG_TERNARY_MODE: ternary_next = cfg_wdata[0];
                default: ;
            endcase
            cnt_next = '0;
            col_next = '0;
            row_next = '0;
            ptr_next = '0;
        end else if (adv) begin
            ptr_next = (WW'(ptr_reg) + WW'(2) >= w_reg) ? '0 : ptr_reg + XW'(1);
            if (produce) begin
                if (col_end) begin
                    col_next = '0;
                    if (row_end) begin
                        row_next = '0;
                        cnt_next = '0;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + XW'(1);
                end
            end else begin
                cnt_next = cnt_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= WW'(RESET_W);
            h_reg       <= HGT_W'(RESET_HEIGHT);
            radius_reg  <= RAD_W'(RESET_RADIUS);
            ternary_reg <= 1'b0;
            cnt_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            radius_reg  <= radius_next;
            ternary_reg <= ternary_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && produce) begin
            pend_col_reg  <= col_reg;
            pend_row_reg  <= row_reg;
            pend_last_reg <= frame_end;
        end
    end

    assign step.adv     = adv;
    assign step.move    = move;
    assign step.bypass  = (w_reg == WW'(1));
    assign step.last    = pend_last_reg;
    assign step.ternary = ternary_reg;
    assign step.radius  = radius_reg;
    assign ptr          = ptr_reg;
    assign col          = pend_col_reg;
    assign row          = pend_row_reg;
    assign img_w        = w_reg;
    assign img_h        = h_reg;

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_reg) < w_reg)
        else $error("column position beyond row width");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= delay)
        else $error("item count ran past window delay");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && produce && frame_end && !cfg_wen |=> cnt_reg == '0 && col_reg == '0)
        else $error("frame did not restart after last pixel");

endmodule

[sv/window_census_transform_core.sv]
// Census transform over a square window of side 2*radius+1 on an 8-bit grey
// image streamed in raster order, one word per pixel and one per clock while
// m_tready is high. Window positions outside the image read as zero. After
// the last pixel of a frame the source sends D = radius*image_width+radius
// flush words (s_tuser = 1); pixel k's code is registered onto m_tdata after
// input word k+D is taken, and m_tlast marks the frame's final pixel. The
// window is fed by a chain of line cells, each a single-port byte memory of
// MAX_WIDTH-1 entries read and written at the same address every word; line
// contents need no clearing after reset. s_tready follows m_tready
// combinationally while a result is pending and m_tvalid is high.
// Configuration writes restart the frame and must be issued while idle.
module window_census_transform_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [wct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wct_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel
    input  logic [0:0]                     s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // [47:0] census_code
    output logic                           m_tlast
);
    import wct_pkg::*;

    localparam int TAPS = 2 * MAX_RADIUS + 1;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);

    wct_step_t                             step;
    logic [XW-1:0]                         ptr;
    logic [XW-1:0]                         col;
    logic [ROW_W-1:0]                      row;
    logic [WW-1:0]                         img_w;
    logic [HGT_W-1:0]                      img_h;
    logic                                  out_free;
    logic [PIX_W-1:0]                      pix_in;
    logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0]  win;
    logic [CODE_W-1:0]                     code;

    logic                                  m_tvalid_reg;
    logic [CODE_W-1:0]                     m_tdata_reg;
    logic                                  m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pix_in   = s_tuser[0] ? '0 : s_tdata;

    wct_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .out_free  (out_free),
        .step      (step),
        .ptr       (ptr),
        .col       (col),
        .row       (row),
        .img_w     (img_w),
        .img_h     (img_h)
    );

    for (genvar j = 0; j < TAPS; j++) begin : g_row
        wct_row_cell #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_RADIUS (MAX_RADIUS)
        ) u_cell (
            .aclk   (aclk),
            .adv    (step.adv),
            .bypass ((j == 0) ? 1'b1 : step.bypass),
            .ptr    (ptr),
            .din    ((j == 0) ? pix_in : win[(j > 0) ? j - 1 : 0][0]),
            .taps   (win[j])
        );
    end

    wct_census #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_census (
        .win     (win),
        .row     (row),
        .col     (col),
        .img_w   (img_w),
        .img_h   (img_h),
        .radius  (step.radius),
        .ternary (step.ternary),
        .code    (code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step.move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.move) begin
            m_tdata_reg <= code;
            m_tlast_reg <= step.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
